FILE: rtl/lobm_pkg.sv
// shared types and constants of the order book matcher
`default_nettype none
package lobm_pkg;

  localparam int unsigned ORDER_SLOTS = 32;
  localparam int unsigned SLOT_W = $clog2(ORDER_SLOTS);

  localparam logic [1:0] CMD_LIMIT  = 2'd0;
  localparam logic [1:0] CMD_MARKET = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_IGNORE = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [31:0] cancel_id;
  } cmd_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] fill_price;
    logic [31:0] fill_volume;
    logic [31:0] assigned_id;
    logic        book_full;
    logic        last;
  } res_item_t;

  // one resting order as held in the slot memory
  typedef struct packed {
    logic        side;
    logic        is_market;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] order_id;
  } slot_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: rtl/limit_order_book_matcher_unit.sv
// top level of the order book matcher: sequencer, valid bits and slot memory
//
// channel | direction | handshake            | payload
// command | in        | start / busy         | cmd_i   (cmd_item_t)
// result  | out       | res_valid_o (strobe) | res_o   (res_item_t)
//
// a scan reads all N = ORDER_SLOTS slots through the single memory read port,
// one slot a cycle; a fill or a completion is a state of its own after the scan.
// a command scans once per fill and once more when a remainder is left; a limit or
// market buy also scans once for the lowest price. cancel scans once, a market sell
// not at all. reset clears valid bits and the id counter at once, no clearing
// pass. results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module limit_order_book_matcher_unit
  import lobm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire cmd_item_t cmd_i,
  output logic           res_valid_o,
  output res_item_t      res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LEVEL = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_CANC  = 3'd5;

  localparam logic [SLOT_W:0] LAST_CNT = (SLOT_W + 1)'(ORDER_SLOTS);

  logic [2:0]        st_q, st_d;
  logic [SLOT_W:0]   cnt_q, cnt_d;        // read address counter, spans depth
  logic              pend_q, pend_d;      // read data of cnt_q-1 arrives now
  logic [SLOT_W-1:0] paddr_q, paddr_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]       next_id_q, next_id_d;
  cmd_item_t         cmd_q, cmd_d;
  logic [31:0]       vol_q, vol_d;
  logic [31:0]       level_q, level_d;
  logic              any_q, any_d;
  logic              best_ok_q, best_ok_d;
  logic [SLOT_W-1:0] best_q, best_d;
  slot_t             bslot_q, bslot_d;
  logic              rv_q, rv_d;
  res_item_t         res_q, res_d;

  mem_req_t req;
  slot_t    rd;

  lobm_slot_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd)
  );

  logic        is_buy, is_mkt, rd_ok, better;
  logic [31:0] age_rd, age_b, fprice;
  logic [SLOT_W-1:0] free_s;
  logic        free_ok;

  assign is_buy = (cmd_q.side == SIDE_BUY);
  assign is_mkt = (cmd_q.command == CMD_MARKET);
  assign age_rd = next_id_q - rd.order_id;
  assign age_b  = next_id_q - bslot_q.order_id;
  assign fprice = is_mkt ? bslot_q.price : cmd_q.limit_price;

  // candidate test for the slot whose data is on the read port
  always_comb begin
    rd_ok  = 1'b0;
    better = 1'b0;
    if (valid_q[paddr_q]) begin
      if (is_buy) begin
        rd_ok  = (rd.side == SIDE_SELL);
        better = !best_ok_q || (rd.price < bslot_q.price) ||
                 ((rd.price == bslot_q.price) && (age_rd > age_b));
      end else begin
        rd_ok  = (rd.side == SIDE_BUY) &&
                 (rd.is_market || !(rd.price < cmd_q.limit_price));
        better = !best_ok_q || (age_rd > age_b);
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_s  = '0;
    free_ok = 1'b0;
    for (int s = ORDER_SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_s  = SLOT_W'(s);
        free_ok = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    paddr_d   = paddr_q;
    valid_d   = valid_q;
    next_id_d = next_id_q;
    cmd_d     = cmd_q;
    vol_d     = vol_q;
    level_d   = level_q;
    any_d     = any_q;
    best_ok_d = best_ok_q;
    best_d    = best_q;
    bslot_d   = bslot_q;
    rv_d      = 1'b0;
    res_d     = res_q;
    req       = '0;
    req.rd_addr = cnt_q[SLOT_W-1:0];
    req.wr_addr = best_q;
    req.wr_data = bslot_q;

    // issue reads while sweeping
    if ((st_q == ST_LEVEL || st_q == ST_SCAN || st_q == ST_CANC) &&
        cnt_q != LAST_CNT) begin
      req.rd_en = 1'b1;
      pend_d    = 1'b1;
      paddr_d   = cnt_q[SLOT_W-1:0];
      cnt_d     = cnt_q + (SLOT_W + 1)'(1);
    end

    case (st_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d     = cmd_i;
          vol_d     = cmd_i.quantity;
          cnt_d     = '0;
          any_d     = 1'b0;
          level_d   = '0;
          best_ok_d = 1'b0;
          case (cmd_i.command)
            CMD_CANCEL: st_d = ST_CANC;
            CMD_LIMIT:  st_d = (cmd_i.side == SIDE_BUY) ? ST_LEVEL : ST_SCAN;
            CMD_MARKET: st_d = (cmd_i.side == SIDE_BUY) ? ST_LEVEL : ST_DONE;
            default:    st_d = ST_IDLE;
          endcase
        end
      end
      ST_CANC: begin
        if (pend_q && valid_q[paddr_q] && rd.order_id == cmd_q.cancel_id &&
            !any_q) begin
          valid_d[paddr_q] = 1'b0;
          any_d = 1'b1;
        end
        if (!pend_q && cnt_q == LAST_CNT) st_d = ST_IDLE;
      end
      ST_LEVEL: begin
        if (pend_q && valid_q[paddr_q] && (!any_q || rd.price < level_q)) begin
          level_d = rd.price;
          any_d   = 1'b1;
        end
        if (!pend_q && cnt_q == LAST_CNT) begin
          st_d  = ST_SCAN;
          cnt_d = '0;
        end
      end
      ST_SCAN: begin
        if (pend_q && rd_ok && better) begin
          best_ok_d = 1'b1;
          best_d    = paddr_q;
          bslot_d   = rd;
        end
        if (!pend_q && cnt_q == LAST_CNT) begin
          if (!best_ok_q ||
              (is_buy && !is_mkt && bslot_q.price > cmd_q.limit_price)) begin
            st_d = ST_DONE;
          end else begin
            st_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        rv_d = 1'b1;
        res_d = '0;
        res_d.kind       = KIND_FILL;
        res_d.fill_price = fprice;
        if (bslot_q.volume > vol_q) begin
          res_d.fill_volume = vol_q;
          req.wr_en = 1'b1;
          req.wr_data.volume = bslot_q.volume - vol_q;
          cmd_d.command = CMD_IGNORE;   // matched fully, nothing rests
          st_d = ST_DONE;
        end else if (bslot_q.volume == vol_q) begin
          res_d.fill_volume = vol_q;
          valid_d[best_q] = 1'b0;
          cmd_d.command = CMD_IGNORE;
          st_d = ST_DONE;
        end else begin
          res_d.fill_volume = bslot_q.volume;
          vol_d = vol_q - bslot_q.volume;
          valid_d[best_q] = 1'b0;
          if (is_mkt) level_d = bslot_q.price;
          cnt_d     = '0;
          best_ok_d = 1'b0;
          st_d      = ST_SCAN;
        end
      end
      ST_DONE: begin
        rv_d  = 1'b1;
        res_d = '0;
        res_d.kind        = KIND_DONE;
        res_d.assigned_id = next_id_q;
        res_d.last        = 1'b1;
        // rest the remainder unless fully matched or a market sell
        if ((cmd_q.command == CMD_LIMIT) ||
            (cmd_q.command == CMD_MARKET && is_buy)) begin
          if (free_ok) begin
            valid_d[free_s] = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = free_s;
            req.wr_data.side      = cmd_q.side;
            req.wr_data.is_market = is_mkt;
            req.wr_data.price     = is_mkt ? level_q : cmd_q.limit_price;
            req.wr_data.volume    = vol_q;
            req.wr_data.order_id  = next_id_q;
          end else begin
            res_d.book_full = 1'b1;
          end
        end
        next_id_d = next_id_q + 32'd1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      valid_q   <= '0;
      next_id_q <= '0;
      rv_q      <= 1'b0;
      best_ok_q <= 1'b0;
      any_q     <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      valid_q   <= valid_d;
      next_id_q <= next_id_d;
      rv_q      <= rv_d;
      best_ok_q <= best_ok_d;
      any_q     <= any_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    cmd_q   <= cmd_d;
    vol_q   <= vol_d;
    level_q <= level_d;
    best_q  <= best_d;
    bslot_q <= bslot_d;
    res_q   <= res_d;
  end

  assign busy        = (st_q != ST_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // a completion is always the last result
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.kind == res_o.last))
    else $error("kind and last disagree");

  // the id counter moves only with a completion
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != $past(next_id_q)) |-> (res_valid_o && res_o.kind == KIND_DONE))
    else $error("id advanced without completion");

  // no result while idle on the previous cycle
  a_no_idle_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && !start) |=> !res_valid_o)
    else $error("result from idle");

endmodule
`default_nettype wire

FILE: rtl/lobm_slot_mem.sv
// slot memory: one write port, one read port with registered data
`default_nettype none
module lobm_slot_mem
  import lobm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output slot_t         rd_data_o
);

  slot_t mem_q [ORDER_SLOTS];
  slot_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read port with registered data, updated only on a read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

FILE: bench/lobm_checker.sv
// checker for the order book matcher: predicts results of each command and compares
`default_nettype none
module lobm_checker
  import lobm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire cmd_item_t cmd_i,
  input  wire logic      res_valid_o,
  input  wire res_item_t res_o,
  output int unsigned    fail_count,
  output int unsigned    pending_count,
  output int unsigned    fill_count,
  output int unsigned    full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted book contents
  logic        bk_valid  [ORDER_SLOTS];
  logic        bk_side   [ORDER_SLOTS];
  logic        bk_market [ORDER_SLOTS];
  logic [31:0] bk_price  [ORDER_SLOTS];
  logic [31:0] bk_volume [ORDER_SLOTS];
  logic [31:0] bk_id     [ORDER_SLOTS];
  logic [31:0] id_counter;

  res_item_t expected_results[$];

  function automatic logic [31:0] age(int s);
    return id_counter - bk_id[s];
  endfunction

  // lowest priced resting sell, oldest first
  function automatic int cheapest_sell();
    int best;
    best = -1;
    for (int s = 0; s < ORDER_SLOTS; s++) begin
      if (!bk_valid[s] || bk_side[s] != SIDE_SELL) continue;
      if (best < 0 || bk_price[s] < bk_price[best] ||
          (bk_price[s] == bk_price[best] && age(s) > age(best))) best = s;
    end
    return best;
  endfunction

  // oldest bid eligible for a sell at price p
  function automatic int oldest_bid(logic [31:0] p);
    int best;
    best = -1;
    for (int s = 0; s < ORDER_SLOTS; s++) begin
      if (!bk_valid[s] || bk_side[s] != SIDE_BUY) continue;
      if (!bk_market[s] && bk_price[s] < p) continue;
      if (best < 0 || age(s) > age(best)) best = s;
    end
    return best;
  endfunction

  task automatic push_result(logic k, logic [31:0] p, logic [31:0] v, logic [31:0] id,
                             logic full, logic lst);
    res_item_t r;
    r.kind = k; r.fill_price = p; r.fill_volume = v;
    r.assigned_id = id; r.book_full = full; r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endtask

  // apply one command to the predicted book
  task automatic match_command(cmd_item_t c);
    logic        is_mkt, done;
    logic [31:0] vol, level, id, p;
    logic        any;
    int          s, f;
    is_mkt = (c.command == CMD_MARKET);
    done = 0; level = '0; any = 0; vol = c.quantity;
    if (c.command == CMD_CANCEL) begin
      for (int k = 0; k < ORDER_SLOTS; k++)
        if (bk_valid[k] && bk_id[k] == c.cancel_id) begin
          bk_valid[k] = 0;
          break;
        end
      return;
    end
    if (c.command != CMD_LIMIT && c.command != CMD_MARKET) return;
    id = id_counter;
    if (is_mkt && c.side == SIDE_SELL) begin
      id_counter++;
      push_result(KIND_DONE, '0, '0, id, 1'b0, 1'b1);
      return;
    end
    if (c.side == SIDE_BUY) begin
      for (int k = 0; k < ORDER_SLOTS; k++)
        if (bk_valid[k] && (!any || bk_price[k] < level)) begin
          level = bk_price[k];
          any = 1;
        end
      forever begin
        s = cheapest_sell();
        if (s < 0) break;
        if (!is_mkt && bk_price[s] > c.limit_price) break;
        p = is_mkt ? bk_price[s] : c.limit_price;
        if (bk_volume[s] >= vol) begin
          if (bk_volume[s] == vol) bk_valid[s] = 0;
          else bk_volume[s] -= vol;
          push_result(KIND_FILL, p, vol, '0, 1'b0, 1'b0);
          done = 1;
          break;
        end
        push_result(KIND_FILL, p, bk_volume[s], '0, 1'b0, 1'b0);
        vol -= bk_volume[s];
        bk_valid[s] = 0;
        if (is_mkt) level = bk_price[s];
      end
    end else begin
      forever begin
        s = oldest_bid(c.limit_price);
        if (s < 0) break;
        if (bk_volume[s] >= vol) begin
          if (bk_volume[s] == vol) bk_valid[s] = 0;
          else bk_volume[s] -= vol;
          push_result(KIND_FILL, c.limit_price, vol, '0, 1'b0, 1'b0);
          done = 1;
          break;
        end
        push_result(KIND_FILL, c.limit_price, bk_volume[s], '0, 1'b0, 1'b0);
        vol -= bk_volume[s];
        bk_valid[s] = 0;
      end
    end
    f = -1;
    if (!done) begin
      for (int k = 0; k < ORDER_SLOTS; k++)
        if (!bk_valid[k]) begin
          f = k;
          break;
        end
      if (f >= 0) begin
        bk_valid[f] = 1; bk_side[f] = c.side; bk_market[f] = is_mkt;
        bk_price[f] = is_mkt ? level : c.limit_price;
        bk_volume[f] = vol; bk_id[f] = id;
      end else full_count++;
    end
    id_counter++;
    push_result(KIND_DONE, '0, '0, id, (!done && f < 0), 1'b1);
  endtask

  assign pending_count = expected_results.size();

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_item_t want;
    if (!rst_ni) begin
      for (int k = 0; k < ORDER_SLOTS; k++) begin
        bk_valid[k] = 0; bk_side[k] = 0; bk_market[k] = 0;
        bk_price[k] = 0; bk_volume[k] = 0; bk_id[k] = 0;
      end
      id_counter = '0;
      expected_results.delete();
      fail_count = 0; fill_count = 0; full_count = 0;
    end else begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $realtime, res_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_o.kind == KIND_FILL) fill_count++;
          if (res_o !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $realtime, want, res_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) match_command(cmd_i);
    end
  end
endmodule
`default_nettype wire

FILE: bench/tb.sv
// top of the order book matcher testbench: stimulus, watchdog and verdict
`default_nettype none
module tb;
  import lobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  cmd_item_t   cmd_i = '0;
  logic        res_valid_o;
  res_item_t   res_o;
  int unsigned fail_count, pending_count, fill_count, full_count;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  logic        quiet_tail = 0;
  logic [31:0] ids_issued = 0;

  limit_order_book_matcher_unit uut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .res_valid_o, .res_o
  );

  lobm_checker chk (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .res_valid_o, .res_o,
    .fail_count, .pending_count, .fill_count, .full_count
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // watchdog on cycles with no accepted item or result
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hand one item over and hold it until accepted
  task automatic issue(logic [1:0] c, logic sd, logic [31:0] p, logic [31:0] q,
                       logic [31:0] cid);
    cmd_item_t it;
    it.command = c; it.side = sd; it.limit_price = p; it.quantity = q; it.cancel_id = cid;
    @(negedge clk_i);
    cmd_i <= it;
    start <= 1;
    do @(posedge clk_i); while (busy);
    if (c == CMD_LIMIT || c == CMD_MARKET) ids_issued++;
    sent++;
    @(negedge clk_i);
    start <= 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // one random command, mostly small prices and volumes so that orders cross
  task automatic random_command();
    logic [1:0]  c;
    logic [31:0] p, q, cid;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 60) c = CMD_LIMIT;
    else if (r < 75) c = CMD_MARKET;
    else if (r < 95) c = CMD_CANCEL;
    else c = CMD_IGNORE;
    p = ($urandom_range(0, 9) == 0) ? $urandom : 32'd100 + $urandom_range(0, 12);
    q = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
    cid = ($urandom_range(0, 7) == 0) ? $urandom
        : ids_issued - $urandom_range(1, 40);
    issue(c, 1'($urandom_range(0, 1)), p, q, cid);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: crossing, sweeps, market orders, cancels, extremes
    issue(CMD_LIMIT, SIDE_SELL, 32'd100, 32'd10, 0);
    issue(CMD_LIMIT, SIDE_SELL, 32'd100, 32'd0, 0);
    issue(CMD_LIMIT, SIDE_SELL, 32'd90, 32'd5, 0);
    issue(CMD_LIMIT, SIDE_BUY, 32'd95, 32'd3, 0);
    issue(CMD_LIMIT, SIDE_BUY, 32'd100, 32'd20, 0);
    issue(CMD_MARKET, SIDE_BUY, 32'd0, 32'd7, 0);
    issue(CMD_LIMIT, SIDE_SELL, 32'd0, 32'd4, 0);
    issue(CMD_MARKET, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue(CMD_LIMIT, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue(CMD_LIMIT, SIDE_SELL, 32'hFFFF_FFFF, 32'd1, 0);
    issue(CMD_CANCEL, SIDE_BUY, 0, 0, 32'd8);
    issue(CMD_CANCEL, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_IGNORE, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the table to overflow, then sweep it with one large buy
    for (int k = 0; k < 34; k++) issue(CMD_LIMIT, SIDE_SELL, 32'd200 + k, 32'd1, 0);
    drain();
    issue(CMD_MARKET, SIDE_BUY, 0, 32'd100, 0);
    drain();
    // random part
    for (int k = 0; k < 112; k++) begin
      if (k == 90) quiet_tail = 1;
      random_command();
      if (k == 60) drain();
    end
    drain();
    $display("covered %0d items, %0d fills, %0d dropped remainders on a full book",
             sent, fill_count, full_count);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/lobm_pkg.sv
rtl/lobm_slot_mem.sv
rtl/limit_order_book_matcher_unit.sv
bench/lobm_checker.sv
bench/tb.sv
